@@ rtl/rcd_pkg.sv @@
package rcd_pkg;

    localparam int unsigned ChanW      = 8;
    localparam int unsigned SumW       = 29;
    localparam int unsigned QuotW      = 32;
    localparam int unsigned RootW      = 16;
    localparam int unsigned RemW       = 26;
    localparam int unsigned SqrtRemW   = RootW + 2;
    localparam int unsigned SqrtSteps  = QuotW / 2;
    localparam int unsigned FracBits   = 14;
    localparam int unsigned EstShift   = 30;
    localparam int unsigned RecipW     = 34;
    localparam int unsigned WeightW    = 11;
    localparam int unsigned SqW        = 2 * ChanW;
    localparam int unsigned ProdW      = WeightW + SqW;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW  = 2;

    localparam logic [24:0]        RedmeanScale  = 25'd33162750;
    localparam logic [WeightW-1:0] RedWeightBase = 11'd1020;
    localparam logic [WeightW-1:0] GreenWeight   = 11'd2040;
    localparam logic [WeightW-1:0] BlueWeightBase = 11'd1530;

    // Reciprocal of the scale, 2^58 / scale, so that N * Recip >> 30
    // underestimates floor(N * 2^28 / scale) by at most one.
    localparam logic [63:0] RecipFull =
        (64'd1 << (2 * FracBits + EstShift)) / {39'd0, RedmeanScale};
    localparam logic [RecipW-1:0] Recip = RecipFull[RecipW-1:0];

    typedef logic [SumW-1:0]  sum_t;
    typedef logic [QuotW-1:0] quot_t;
    typedef logic [RootW-1:0] root_t;

    typedef struct packed {
        logic valid;
        sum_t n;
    } rcd_sum_item_t;

    typedef struct packed {
        logic  valid;
        sum_t  n;
        quot_t q;
    } rcd_quot_item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } rcd_queue_status_t;

endpackage

@@ rtl/rcd_front.sv @@
module rcd_front
    import rcd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [ChanW-1:0]    a_red,
    input  logic [ChanW-1:0]    a_green,
    input  logic [ChanW-1:0]    a_blue,
    input  logic [ChanW-1:0]    b_red,
    input  logic [ChanW-1:0]    b_green,
    input  logic [ChanW-1:0]    b_blue,
    output rcd_sum_item_t       out_item
);

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic [ChanW-1:0]   dr_reg, dg_reg, db_reg;
    logic [ChanW:0]     rsum_reg;
    logic [SqW-1:0]     dr2_reg, dg2_reg, db2_reg;
    logic [WeightW-1:0] wr_reg, wb_reg;
    logic [ProdW-1:0]   pr_reg, pg_reg, pb_reg;
    sum_t               n_reg;

    logic [ChanW-1:0]   dr_next, dg_next, db_next;
    logic [ChanW:0]     rsum_next;
    logic [ProdW-1:0]   pr_next, pg_next, pb_next;
    sum_t               n_next;

    always_comb
    begin
        dr_next   = (a_red >= b_red) ? a_red - b_red : b_red - a_red;
        dg_next   = (a_green >= b_green) ? a_green - b_green : b_green - a_green;
        db_next   = (a_blue >= b_blue) ? a_blue - b_blue : b_blue - a_blue;
        rsum_next = {1'b0, a_red} + {1'b0, b_red};
        pr_next   = {{SqW{1'b0}}, wr_reg} * {{WeightW{1'b0}}, dr2_reg};
        pg_next   = {{SqW{1'b0}}, GreenWeight} * {{WeightW{1'b0}}, dg2_reg};
        pb_next   = {{SqW{1'b0}}, wb_reg} * {{WeightW{1'b0}}, db2_reg};
        n_next    = {2'b00, pr_reg} + {2'b00, pg_reg} + {2'b00, pb_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dr_reg   <= dr_next;
            dg_reg   <= dg_next;
            db_reg   <= db_next;
            rsum_reg <= rsum_next;
            dr2_reg  <= {{ChanW{1'b0}}, dr_reg} * {{ChanW{1'b0}}, dr_reg};
            dg2_reg  <= {{ChanW{1'b0}}, dg_reg} * {{ChanW{1'b0}}, dg_reg};
            db2_reg  <= {{ChanW{1'b0}}, db_reg} * {{ChanW{1'b0}}, db_reg};
            wr_reg   <= RedWeightBase + {2'b00, rsum_reg};
            wb_reg   <= BlueWeightBase - {2'b00, rsum_reg};
            pr_reg   <= pr_next;
            pg_reg   <= pg_next;
            pb_reg   <= pb_next;
            n_reg    <= n_next;
        end
    end

    assign out_item.valid = v4_reg;
    assign out_item.n     = n_reg;

endmodule

@@ rtl/rcd_queue.sv @@
module rcd_queue
    import rcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sum_t              push_n,
    input  logic              pop,
    output sum_t              head_n,
    output rcd_queue_status_t status
);

    sum_t                 mem_reg [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QueuePtrW:0]   count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_n;
        end
    end

    assign head_n       = mem_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == (QueuePtrW + 1)'(QueueDepth));

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue read while empty");

    a_fill_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> !status.empty)
        else $error("queue empty right after a write");

endmodule

@@ rtl/rcd_scale.sv @@
module rcd_scale
    import rcd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  rcd_sum_item_t  in_item,
    output rcd_quot_item_t out_item
);

    localparam int unsigned LoW   = 16;
    localparam int unsigned HiW   = SumW - LoW;
    localparam int unsigned PloW  = LoW + RecipW;
    localparam int unsigned PhiW  = HiW + RecipW;
    localparam int unsigned FullW = SumW + RecipW;

    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    sum_t              n1_reg, n2_reg, n3_reg, n4_reg;
    logic [PloW-1:0]   plo_reg;
    logic [PhiW-1:0]   phi_reg;
    quot_t             qest2_reg, qest3_reg, q_reg;
    logic [RemW-1:0]   low_reg;

    logic [PloW-1:0]   plo_next;
    logic [PhiW-1:0]   phi_next;
    logic [FullW-1:0]  prod;
    quot_t             qest_next;
    logic [2*RemW-1:0] low_full;
    logic [RemW-1:0]   rem;
    logic              bump;
    quot_t             q_next;

    always_comb
    begin
        plo_next  = {{RecipW{1'b0}}, in_item.n[LoW-1:0]} * {{LoW{1'b0}}, Recip};
        phi_next  = {{RecipW{1'b0}}, in_item.n[SumW-1:LoW]} * {{HiW{1'b0}}, Recip};
        prod      = {phi_reg, {LoW{1'b0}}} + {{(FullW - PloW){1'b0}}, plo_reg};
        qest_next = prod[EstShift +: QuotW];
        // Only the low bits of q_est * scale matter: the remainder is below 2^26.
        low_full  = {{RemW{1'b0}}, qest2_reg[RemW-1:0]}
                  * {{(2 * RemW - 25){1'b0}}, RedmeanScale};
        rem       = {RemW{1'b0}} - low_reg;
        bump      = (rem >= {1'b0, RedmeanScale});
        q_next    = qest3_reg + {{(QuotW - 1){1'b0}}, bump};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_item.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg    <= in_item.n;
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
            n2_reg    <= n1_reg;
            qest2_reg <= qest_next;
            n3_reg    <= n2_reg;
            qest3_reg <= qest2_reg;
            low_reg   <= low_full[RemW-1:0];
            n4_reg    <= n3_reg;
            q_reg     <= q_next;
        end
    end

    assign out_item.valid = v4_reg;
    assign out_item.n     = n4_reg;
    assign out_item.q     = q_reg;

endmodule

@@ rtl/rcd_sqrt.sv @@
module rcd_sqrt
    import rcd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  rcd_quot_item_t in_item,
    output logic           out_valid,
    output sum_t           out_n,
    output root_t          out_root
);

    logic                v_reg    [SqrtSteps];
    sum_t                n_reg    [SqrtSteps];
    quot_t               rad_reg  [SqrtSteps];
    logic [SqrtRemW-1:0] rem_reg  [SqrtSteps];
    root_t               root_reg [SqrtSteps];

    logic                v_src    [SqrtSteps];
    sum_t                n_src    [SqrtSteps];
    quot_t               rad_src  [SqrtSteps];
    logic [SqrtRemW-1:0] rem_src  [SqrtSteps];
    root_t               root_src [SqrtSteps];

    quot_t               rad_next  [SqrtSteps];
    logic [SqrtRemW-1:0] rem_next  [SqrtSteps];
    root_t               root_next [SqrtSteps];

    logic [SqrtRemW-1:0] rem_sh;
    logic [SqrtRemW-1:0] trial;
    logic                take;

    // Each stage settles one root bit from the next two radicand bits.
    always_comb
    begin
        rem_sh = '0;
        trial  = '0;
        take   = 1'b0;
        for (int k = 0; k < SqrtSteps; k++)
        begin
            if (k == 0)
            begin
                v_src[k]    = in_item.valid;
                n_src[k]    = in_item.n;
                rad_src[k]  = in_item.q;
                rem_src[k]  = '0;
                root_src[k] = '0;
            end
            else
            begin
                v_src[k]    = v_reg[k-1];
                n_src[k]    = n_reg[k-1];
                rad_src[k]  = rad_reg[k-1];
                rem_src[k]  = rem_reg[k-1];
                root_src[k] = root_reg[k-1];
            end
            rem_sh       = {rem_src[k][SqrtRemW-3:0], rad_src[k][QuotW-1 -: 2]};
            trial        = {root_src[k], 2'b01};
            take         = (rem_sh >= trial);
            rem_next[k]  = take ? rem_sh - trial : rem_sh;
            root_next[k] = {root_src[k][RootW-2:0], take};
            rad_next[k]  = {rad_src[k][QuotW-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SqrtSteps; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < SqrtSteps; k++)
            begin
                v_reg[k] <= v_src[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SqrtSteps; k++)
            begin
                n_reg[k]    <= n_src[k];
                rad_reg[k]  <= rad_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign out_valid = v_reg[SqrtSteps-1];
    assign out_n     = n_reg[SqrtSteps-1];
    assign out_root  = root_reg[SqrtSteps-1];

endmodule

@@ rtl/redmean_color_distance.sv @@
// Redmean color distance between two 8-bit RGB colors.
//
// Input channel: in_valid / in_ready with the six channel values of colors a
// and b. Output channel: out_valid / out_ready with weighted_square_sum, the
// integer numerator N of the squared distance, and distance_q, the distance
// in unsigned Q2.14 (floor of the square root of N * 2^28 / 33162750).
//
// Throughput is one item per cycle while out_ready is held high. The edge
// that accepts an item loads the first of four front stages that form N.
// The item then passes through the queue, four stages divide by the scale
// through a reciprocal multiply and correction, and sixteen stages take the
// square root one bit per stage.
//
// The front and back are parted by a four-entry queue. When out_ready is low
// and a result is shown, the back pipeline holds it steady on the outputs;
// the front takes items until the queue fills, and only then drops in_ready.
// Reset empties the pipelines and the queue; no result is pending after it.
module redmean_color_distance
    import rcd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [ChanW-1:0] a_red,
    input  logic [ChanW-1:0] a_green,
    input  logic [ChanW-1:0] a_blue,
    input  logic [ChanW-1:0] b_red,
    input  logic [ChanW-1:0] b_green,
    input  logic [ChanW-1:0] b_blue,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [SumW-1:0]  weighted_square_sum,
    output logic [RootW-1:0] distance_q
);

    rcd_sum_item_t     front_item;
    rcd_sum_item_t     scale_in;
    rcd_quot_item_t    scale_out;
    rcd_queue_status_t q_status;
    sum_t              head_n;
    logic              front_en;
    logic              back_en;
    logic              push;
    logic              pop;

    assign front_en = !(front_item.valid && q_status.full);
    assign in_ready = front_en;
    assign push     = front_item.valid && front_en;

    assign back_en  = !out_valid || out_ready;
    assign pop      = back_en && !q_status.empty;

    assign scale_in.valid = !q_status.empty;
    assign scale_in.n     = head_n;

    rcd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (front_en),
        .in_valid (in_valid),
        .a_red    (a_red),
        .a_green  (a_green),
        .a_blue   (a_blue),
        .b_red    (b_red),
        .b_green  (b_green),
        .b_blue   (b_blue),
        .out_item (front_item)
    );

    rcd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .push_n (front_item.n),
        .pop    (pop),
        .head_n (head_n),
        .status (q_status)
    );

    rcd_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (back_en),
        .in_item  (scale_in),
        .out_item (scale_out)
    );

    rcd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (back_en),
        .in_item   (scale_out),
        .out_valid (out_valid),
        .out_n     (weighted_square_sum),
        .out_root  (distance_q)
    );

endmodule
